/* src/bs3_pkg.sv */
// ----------------------------------------------------------------------------
// bs3_pkg - shared types, constants and helpers for the 3x3 binomial smoother
// Result record, register map and the small adder functions of the filter.
// ----------------------------------------------------------------------------
package bs3_pkg;

    localparam int PIX_W      = 8;
    localparam int HSUM_W     = 10;   // horizontal sum, max 4*255
    localparam int VSUM_W     = 12;   // vertical sum, max 4*1020
    localparam int OUT_X_W    = 10;
    localparam int OUT_Y_W    = 12;
    localparam int ROUND_BIAS = 7;

    localparam int FIFO_DEPTH = 8;    // power of two
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int PUSH_MAX   = 4;    // results one pixel can complete

    localparam int PADDR_W    = 4;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;

    typedef enum logic [1:0] {
        REG_BORDER = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]   smoothed;
        logic [OUT_X_W-1:0] out_x;
        logic [OUT_Y_W-1:0] out_y;
        logic               run_last;
        logic               frame_done;
    } t_result;

    // w * weight + plain, weight 2 or 3
    function automatic logic [HSUM_W-1:0] f_hsum_edge(input logic [PIX_W-1:0] w,
                                                      input logic [PIX_W-1:0] plain,
                                                      input logic rep);
        logic [HSUM_W-1:0] extra;
        extra = rep ? HSUM_W'(w) : '0;
        return HSUM_W'({w, 1'b0}) + extra + HSUM_W'(plain);
    endfunction

    function automatic logic [HSUM_W-1:0] f_hsum_mid(input logic [PIX_W-1:0] p2,
                                                     input logic [PIX_W-1:0] p1,
                                                     input logic [PIX_W-1:0] p0);
        return HSUM_W'(p2) + HSUM_W'({p1, 1'b0}) + HSUM_W'(p0);
    endfunction

    // vertical sum for the row above the current one
    function automatic logic [VSUM_W-1:0] f_vsum_mid(input logic [HSUM_W-1:0] older,
                                                     input logic [HSUM_W-1:0] prev,
                                                     input logic [HSUM_W-1:0] hcur,
                                                     input logic row_one,
                                                     input logic rep);
        logic [VSUM_W-1:0] extra;
        extra = rep ? VSUM_W'(prev) : '0;
        if (row_one) begin
            return VSUM_W'({prev, 1'b0}) + extra + VSUM_W'(hcur);
        end
        return VSUM_W'(older) + VSUM_W'({prev, 1'b0}) + VSUM_W'(hcur);
    endfunction

    // vertical sum for the bottom row itself
    function automatic logic [VSUM_W-1:0] f_vsum_last(input logic [HSUM_W-1:0] prev,
                                                      input logic [HSUM_W-1:0] hcur,
                                                      input logic rep);
        logic [VSUM_W-1:0] extra;
        extra = rep ? VSUM_W'(hcur) : '0;
        return VSUM_W'(prev) + VSUM_W'({hcur, 1'b0}) + extra;
    endfunction

    // (s + 7) / 16, low 8 bits
    function automatic logic [PIX_W-1:0] f_round(input logic [VSUM_W-1:0] s);
        logic [VSUM_W:0] t;
        t = {1'b0, s} + (VSUM_W+1)'(ROUND_BIAS);
        return t[VSUM_W-1:4];
    endfunction

endpackage

/* src/binomial_smooth_3x3_stream.sv */
// ----------------------------------------------------------------------------
// binomial_smooth_3x3_stream - streaming 3x3 binomial smoothing filter
// Raster-order grey pixels in, [1 2 1]x[1 2 1] smoothed pixels with their
// coordinates out. Two rows of horizontal sums live in one line buffer.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+---------------------------------------
//  pixel in  | in  | i_valid/o_stall  | i_pixel
//  result out| out | o_valid/i_stall  | o_smoothed o_out_x o_out_y
//            |     |                  | o_run_last o_frame_done
//  config    | in  | APB psel/penable | border_replicate, image_width,
//            |     |                  | image_height at 0x0, 0x4, 0x8
//
//  - One pixel request per clock while o_stall is low. Its results enter the
//    output queue at the edge after acceptance (line buffer read on the
//    accepting edge, sums in the following cycle); once queued they can leave.
//  - The output queue drains one result per clock while i_stall is low, so on
//    every row but the bottom one the rate is one pixel per clock; the bottom
//    row yields two results per pixel, so the queue drain limits its rate.
//  - o_stall rises when the 8-entry queue might not hold the worst case of
//    four results; it is also high during reset.
//  - Reset (i_rst_n low, synchronous) clears counters, held pixels, queue
//    and config; the line buffer is not cleared (row 0 writes every column
//    before any read whose data a result uses).
//  - i_stall only holds the queue head; the front end keeps going until o_stall rises.
//
module binomial_smooth_3x3_stream
    import bs3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel requests
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    // result requests
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PIX_W-1:0]     o_smoothed,
    output logic [OUT_X_W-1:0]   o_out_x,
    output logic [OUT_Y_W-1:0]   o_out_y,
    output logic                 o_run_last,
    output logic                 o_frame_done,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LB_W = 2 * HSUM_W;   // {older row, newer row}

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic               r_border;
    logic [IMG_W_W-1:0] r_image_width;
    logic [IMG_H_W-1:0] r_image_height;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic               cfg_restart;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign cfg_idx     = t_reg_idx'(paddr[3:2]);
    assign cfg_restart = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border       <= 1'b0;
            r_image_width  <= IMG_W_W'(1024);
            r_image_height <= IMG_H_W'(1024);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BORDER: r_border       <= pwdata[0];
                REG_WIDTH:  r_image_width  <= pwdata[IMG_W_W-1:0];
                REG_HEIGHT: r_image_height <= pwdata[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BORDER: prdata = {31'b0, r_border};
            REG_WIDTH:  prdata = 32'(r_image_width);
            REG_HEIGHT: prdata = 32'(r_image_height);
            default:    prdata = '0;
        endcase
    end

    // Effective last column / last row, clamped to [1, MAX-1] (image size [2, MAX])
    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;

    always_comb begin
        if (r_image_width < IMG_W_W'(2)) begin
            last_col = CW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(r_image_width - IMG_W_W'(1));
        end
        if (r_image_height < IMG_H_W'(2)) begin
            last_row = RW'(1);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            last_row = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row = RW'(r_image_height - IMG_H_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Raster position and held pixels
    // ------------------------------------------------------------------
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [PIX_W-1:0] r_pb1;
    logic [PIX_W-1:0] r_pb2;
    logic             acc;
    logic             at_end;
    logic             at_last_row;

    assign acc         = i_valid && !o_stall;
    assign at_end      = (r_col == last_col);
    assign at_last_row = (r_row == last_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_pb1 <= '0;
            r_pb2 <= '0;
        end else begin
            if (cfg_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (acc) begin
                if (at_end) begin
                    r_col <= '0;
                    r_row <= at_last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (acc) begin
                r_pb2 <= r_pb1;
                r_pb1 <= i_pixel;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 register: the accepted pixel and its context
    // ------------------------------------------------------------------
    logic             r_s1_vld;
    logic [PIX_W-1:0] r_s1_pix;
    logic [PIX_W-1:0] r_s1_pb1;
    logic [PIX_W-1:0] r_s1_pb2;
    logic [CW-1:0]    r_s1_x;
    logic [RW-1:0]    r_s1_y;
    logic             r_s1_end;
    logic             r_s1_last_row;
    logic             r_s1_first_row;
    logic             r_s1_row_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix       <= i_pixel;
            r_s1_pb1       <= r_pb1;
            r_s1_pb2       <= r_pb2;
            r_s1_x         <= r_col;
            r_s1_y         <= r_row;
            r_s1_end       <= at_end;
            r_s1_last_row  <= at_last_row;
            r_s1_first_row <= (r_row == '0);
            r_s1_row_one   <= (r_row == RW'(1));
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: word c = {hsum of row r-2, hsum of row r-1} for column c.
    // Port A reads the column left of the new pixel, port B the pixel's own
    // column (used only at the row end). One write per clock; the row-end
    // column's write is parked and done in the cycle after, when the next pixel is column 0.
    // ------------------------------------------------------------------
    logic [LB_W-1:0] r_lbuf [MAX_WIDTH];
    logic [LB_W-1:0] r_rd_a;
    logic [LB_W-1:0] r_rd_b;
    logic            r_fwd_a;
    logic            r_fwd_b;
    logic [LB_W-1:0] r_fwd_data;
    logic [CW-1:0]   addr_a;
    logic [CW-1:0]   addr_b;

    logic            r_pend_vld;
    logic [CW-1:0]   r_pend_addr;
    logic [LB_W-1:0] r_pend_data;

    logic            s1_wr_a;
    logic            wr_en;
    logic [CW-1:0]   wr_addr;
    logic [LB_W-1:0] wr_data;
    logic [LB_W-1:0] word_a;
    logic [LB_W-1:0] word_b;

    assign addr_a = (r_col == '0) ? '0 : r_col - CW'(1);
    assign addr_b = r_col;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_lbuf[wr_addr] <= wr_data;
        end
    end

    // registered reads with write-through when the same column is written
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_a     <= r_lbuf[addr_a];
            r_rd_b     <= r_lbuf[addr_b];
            r_fwd_a    <= wr_en && (wr_addr == addr_a);
            r_fwd_b    <= wr_en && (wr_addr == addr_b);
            r_fwd_data <= wr_data;
        end
    end

    assign word_a = r_fwd_a ? r_fwd_data : r_rd_a;
    assign word_b = r_fwd_b ? r_fwd_data : r_rd_b;

    // ------------------------------------------------------------------
    // Stage 1 arithmetic
    // ------------------------------------------------------------------
    logic [HSUM_W-1:0] hs_a;     // completed hsum, column x-1
    logic [HSUM_W-1:0] hs_b;     // completed hsum, column x (row end)
    logic [HSUM_W-1:0] old_a;
    logic [HSUM_W-1:0] prev_a;
    logic [HSUM_W-1:0] old_b;
    logic [HSUM_W-1:0] prev_b;
    logic [CW-1:0]     col_a;
    logic [RW-1:0]     row_up;

    assign hs_a = (r_s1_x == CW'(1)) ? f_hsum_edge(r_s1_pb1, r_s1_pix, r_border)
                                     : f_hsum_mid(r_s1_pb2, r_s1_pb1, r_s1_pix);
    assign hs_b = f_hsum_edge(r_s1_pix, r_s1_pb1, r_border);

    assign old_a  = word_a[LB_W-1:HSUM_W];
    assign prev_a = word_a[HSUM_W-1:0];
    assign old_b  = word_b[LB_W-1:HSUM_W];
    assign prev_b = word_b[HSUM_W-1:0];
    assign col_a  = r_s1_x - CW'(1);
    assign row_up = r_s1_y - RW'(1);

    assign s1_wr_a = r_s1_vld && (r_s1_x != '0);
    assign wr_en   = r_pend_vld || s1_wr_a;
    assign wr_addr = r_pend_vld ? r_pend_addr : col_a;
    assign wr_data = r_pend_vld ? r_pend_data : {prev_a, hs_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else begin
            r_pend_vld <= r_s1_vld && r_s1_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && r_s1_end) begin
            r_pend_addr <= r_s1_x;
            r_pend_data <= {prev_b, hs_b};
        end
    end

    // Candidates in output order: A row-1, A row, B row-1, B row
    t_result             cand [PUSH_MAX];
    logic [PUSH_MAX-1:0] cv;
    logic [PTR_W-1:0]    pos  [PUSH_MAX];
    logic [PUSH_MAX-1:0] is_last;
    logic [PTR_W-1:0]    n_push;

    always_comb begin
        cand[0].smoothed   = f_round(f_vsum_mid(old_a, prev_a, hs_a, r_s1_row_one, r_border));
        cand[0].out_x      = OUT_X_W'(col_a);
        cand[0].out_y      = OUT_Y_W'(row_up);
        cand[0].run_last   = is_last[0];
        cand[0].frame_done = 1'b0;

        cand[1].smoothed   = f_round(f_vsum_last(prev_a, hs_a, r_border));
        cand[1].out_x      = OUT_X_W'(col_a);
        cand[1].out_y      = OUT_Y_W'(r_s1_y);
        cand[1].run_last   = is_last[1];
        cand[1].frame_done = 1'b0;

        cand[2].smoothed   = f_round(f_vsum_mid(old_b, prev_b, hs_b, r_s1_row_one, r_border));
        cand[2].out_x      = OUT_X_W'(r_s1_x);
        cand[2].out_y      = OUT_Y_W'(row_up);
        cand[2].run_last   = is_last[2];
        cand[2].frame_done = 1'b0;

        cand[3].smoothed   = f_round(f_vsum_last(prev_b, hs_b, r_border));
        cand[3].out_x      = OUT_X_W'(r_s1_x);
        cand[3].out_y      = OUT_Y_W'(r_s1_y);
        cand[3].run_last   = is_last[3];
        cand[3].frame_done = 1'b1;   // bottom-right pixel
    end

    assign cv[0] = s1_wr_a && !r_s1_first_row;
    assign cv[1] = s1_wr_a && r_s1_last_row;
    assign cv[2] = r_s1_vld && r_s1_end && !r_s1_first_row;
    assign cv[3] = r_s1_vld && r_s1_end && r_s1_last_row;

    // pack valid candidates into consecutive queue slots
    always_comb begin
        logic [PTR_W-1:0] run;
        logic             later;
        run   = '0;
        later = 1'b0;
        for (int k = 0; k < PUSH_MAX; k++) begin
            pos[k] = run;
            run    = run + PTR_W'(cv[k]);
        end
        for (int k = PUSH_MAX - 1; k >= 0; k--) begin
            is_last[k] = cv[k] && !later;
            later      = later || cv[k];
        end
        n_push = run;
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    t_result          r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             pop;
    t_result          head;
    logic [CNT_W:0]   need;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign head    = r_fifo[r_rd_ptr];

    // room for what stage 1 pushes now plus a worst-case next pixel
    assign need    = {1'b0, r_cnt} + (CNT_W+1)'(n_push) + (CNT_W+1)'(PUSH_MAX);
    assign o_stall = !i_rst_n || (need > (CNT_W+1)'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PUSH_MAX; k++) begin
            if (cv[k]) begin
                r_fifo[r_wr_ptr + pos[k]] <= cand[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + n_push;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(n_push) - CNT_W'(pop);
        end
    end

    assign o_smoothed   = head.smoothed;
    assign o_out_x      = head.out_x;
    assign o_out_y      = head.out_y;
    assign o_run_last   = head.run_last;
    assign o_frame_done = head.frame_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend_vld && s1_wr_a))
        else $error("parked row-end write collides with a column write");

    a_pend_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> $past(r_s1_vld && r_s1_end))
        else $error("parked write without a row-end pixel");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> o_run_last)
        else $error("frame end result not marked last of its pixel");

    a_push_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_push != '0) |-> $past(acc))
        else $error("results without an accepted pixel");

endmodule
